// ----- src/object_pool_allocator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Object pool allocator - assertion macros
// Shared property macros for the checker attached to the top level.
// ----------------------------------------------------------------------------
`ifndef OBJECT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define OBJECT_POOL_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define OPA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("object pool check failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define OPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("object pool check failed: next-cycle implication");

`endif

// ----- src/opa_pkg.sv -----
// ----------------------------------------------------------------------------
// Object pool allocator - package
// Pool size, field widths, command and status codes, shared structs.
// ----------------------------------------------------------------------------
package opa_pkg;

    localparam int POOL_SIZE = 256;
    localparam int PTR_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = PTR_W + 1;
    localparam int HANDLE_W  = 8;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRY     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_RELEASED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 2'd3;

    // request to the free-queue RAM
    typedef struct packed {
        logic                wr_en;
        logic [PTR_W-1:0]    wr_addr;
        logic [HANDLE_W-1:0] wr_data;
        logic                rd_en;
        logic [PTR_W-1:0]    rd_addr;
    } ram_req_t;

    // outcome of one request, loaded into the result register
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                from_queue;  // handle comes from the RAM read port
        logic [HANDLE_W-1:0] handle;
    } decision_t;

endpackage

// ----- src/opa_queue_ram.sv -----
// ----------------------------------------------------------------------------
// Object pool allocator - free queue RAM
// One write and one registered read per cycle; no reset on contents.
// ----------------------------------------------------------------------------
module opa_queue_ram
(
    input  logic                         clk,
    input  opa_pkg::ram_req_t            req,
    output logic [opa_pkg::HANDLE_W-1:0] rdata
);
    import opa_pkg::*;

    logic [HANDLE_W-1:0] mem [POOL_SIZE];
    logic [HANDLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/opa_alloc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Object pool allocator - allocation control
// Queue pointers, fresh-handle counter and in-use bitmap; decides each request.
// ----------------------------------------------------------------------------
module opa_alloc_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [opa_pkg::CMD_W-1:0]    cmd,
    input  logic [opa_pkg::HANDLE_W-1:0] hin,
    input  logic [opa_pkg::HANDLE_W-1:0] rdata,
    output opa_pkg::ram_req_t            ram_req,
    output opa_pkg::decision_t           decision
);
    import opa_pkg::*;

    localparam logic [PTR_W-1:0] LAST_POS  = PTR_W'(POOL_SIZE - 1);
    localparam logic [CNT_W-1:0] POOL_CNT  = CNT_W'(POOL_SIZE);
    localparam int               CMP_W     = (HANDLE_W > CNT_W) ? HANDLE_W : CNT_W;
    localparam logic [CMP_W-1:0] POOL_CMP  = CMP_W'(POOL_SIZE);

    logic [PTR_W-1:0]     head_reg,  head_next;
    logic [PTR_W-1:0]     tail_reg,  tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     fresh_reg, fresh_next;
    logic [POOL_SIZE-1:0] map_reg,   map_next;
    // a handle popped last cycle is marked in use once its RAM read returns
    logic                 pend_reg,  pend_next;

    logic [PTR_W-1:0] hin_idx;
    logic             hin_in_range;
    logic             hin_in_use;
    logic             queue_empty;

    always_comb
    begin
        hin_idx      = PTR_W'(hin);
        hin_in_range = CMP_W'(hin) < POOL_CMP;
        queue_empty  = (count_reg == '0);

        map_next = map_reg;
        if (pend_reg)
        begin
            map_next[PTR_W'(rdata)] = 1'b1;
        end
        // forwarded view covers a release of the handle popped last cycle
        hin_in_use = map_next[hin_idx];

        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        fresh_next = fresh_reg;
        pend_next  = 1'b0;

        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = tail_reg;
        ram_req.wr_data = hin;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = head_reg;

        decision.status     = ST_OK;
        decision.from_queue = 1'b0;
        decision.handle     = '0;

        if (go)
        begin
            case (cmd)
                CMD_ALLOC, CMD_TRY:
                begin
                    if (!queue_empty)
                    begin
                        ram_req.rd_en       = 1'b1;
                        head_next           = (head_reg == LAST_POS) ? '0 : head_reg + 1'b1;
                        count_next          = count_reg - 1'b1;
                        pend_next           = 1'b1;
                        decision.from_queue = 1'b1;
                    end
                    else if (cmd == CMD_TRY)
                    begin
                        decision.status = ST_NONE_RELEASED;
                    end
                    else if (fresh_reg >= POOL_CNT)
                    begin
                        decision.status = ST_EXHAUSTED;
                    end
                    else
                    begin
                        map_next[PTR_W'(fresh_reg)] = 1'b1;
                        decision.handle             = HANDLE_W'(fresh_reg);
                        fresh_next                  = fresh_reg + 1'b1;
                    end
                end
                CMD_RELEASE:
                begin
                    if (!hin_in_range || !hin_in_use || (count_reg >= POOL_CNT))
                    begin
                        decision.status = ST_NOT_ALLOCATED;
                    end
                    else
                    begin
                        map_next[hin_idx] = 1'b0;
                        ram_req.wr_en     = 1'b1;
                        tail_next         = (tail_reg == LAST_POS) ? '0 : tail_reg + 1'b1;
                        count_next        = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    // reserved command: no change, ok with handle zero
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= '0;
            map_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
            map_reg   <= map_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// ----- src/object_pool_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Object pool allocator core
// Allocates and releases handles from a fixed pool with a FIFO free queue.
// ----------------------------------------------------------------------------
// One request is taken per cycle while results are drained. A request is held
// in the input register until it advances; on that edge the decision lands in
// the result register and the free-queue RAM read lands in the RAM read
// register, and rsp_valid rises as the result valid register is set. The
// in-use bitmap is flip-flops cleared by reset, so there is no clearing pass
// and the block is ready straight out of reset. Allocate reuses the oldest
// released handle, else mints a fresh one, else reports exhaustion;
// try-allocate reuses released handles only.
module object_pool_allocator_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [opa_pkg::CMD_W-1:0]      command,
    input  logic [opa_pkg::HANDLE_W-1:0]   handle_in,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [opa_pkg::HANDLE_W-1:0]   handle_out,
    output logic [opa_pkg::STATUS_W-1:0]   status
);
    import opa_pkg::*;

    logic                in_vld_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [HANDLE_W-1:0] hin_reg;

    logic                out_vld_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                from_queue_reg;
    logic [HANDLE_W-1:0] handle_reg;

    logic                advance;
    ram_req_t            ram_req;
    decision_t           decision;
    logic [HANDLE_W-1:0] ram_rdata;

    assign advance   = in_vld_reg && (!out_vld_reg || rsp_ready);
    assign req_ready = !in_vld_reg || advance;

    opa_alloc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (advance),
        .cmd      (cmd_reg),
        .hin      (hin_reg),
        .rdata    (ram_rdata),
        .ram_req  (ram_req),
        .decision (decision)
    );

    opa_queue_ram u_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                in_vld_reg <= req_valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            cmd_reg <= command;
            hin_reg <= handle_in;
        end
        if (advance)
        begin
            status_reg     <= decision.status;
            from_queue_reg <= decision.from_queue;
            handle_reg     <= decision.handle;
        end
    end

    // RAM read data holds until the next pop, which cannot happen while stalled
    assign rsp_valid  = out_vld_reg;
    assign status     = status_reg;
    assign handle_out = from_queue_reg ? ram_rdata : handle_reg;

endmodule

// ----- src/opa_checker.sv -----
// ----------------------------------------------------------------------------
// Object pool allocator - port checker
// Observes the top-level ports and checks result and handshake behaviour.
// ----------------------------------------------------------------------------
`include "object_pool_allocator_core_assert.svh"

module opa_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [opa_pkg::HANDLE_W-1:0]   handle_out,
    input logic [opa_pkg::STATUS_W-1:0]   status
);
    import opa_pkg::*;

    logic rsp_stall;

    assign rsp_stall = rsp_valid && !rsp_ready;

    // a stalled result keeps its payload
    `OPA_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(handle_out) && $stable(status))

    // any failed request carries a zero handle
    `OPA_ASSERT_NOW(a_err_zero_handle, rsp_valid && (status != ST_OK), handle_out == '0)

    // with the result side empty the input register always drains
    `OPA_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready)

endmodule

bind object_pool_allocator_core opa_checker u_opa_checker (.*);
